// ===== hdl/atc_pkg.sv =====
// Shared types and constants of the assembly token classifier.
// Transaction structs, kind and error codes, delimiter codes, mnemonic table.
// No dependencies.
package atc_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] token_text;
        logic [2:0]  token_length;
        logic [2:0]  token_kind;
        logic        token_valid;
        logic [1:0]  error_code;
        logic        line_last;
    } t_out_item;

    // token kinds
    localparam logic [2:0] KIND_INSTR  = 3'd0;
    localparam logic [2:0] KIND_REG8   = 3'd1;
    localparam logic [2:0] KIND_ADDR   = 3'd2;
    localparam logic [2:0] KIND_VALUE  = 3'd3;
    localparam logic [2:0] KIND_DELAY  = 3'd4;
    localparam logic [2:0] KIND_SOUND  = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_EMPTY   = 2'd1;
    localparam logic [1:0] ERR_LONG    = 2'd2;

    // delimiters
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SEMI     = 8'h3B;

    localparam int unsigned NUM_MNEM   = 16;

    localparam logic [31:0] MNEM_TEXT [NUM_MNEM] = '{
        {"ADD", 8'h00}, {"SUB", 8'h00}, "SUBN",         {"AND", 8'h00},
        {"OR", 16'h0000}, {"XOR", 8'h00}, {"SE", 16'h0000}, {"SNE", 8'h00},
        {"SYS", 8'h00}, {"JP", 16'h0000}, {"LD", 16'h0000}, {"DRW", 8'h00},
        {"SKP", 8'h00}, "CALL",         {"CLS", 8'h00}, {"RET", 8'h00}
    };

    localparam logic [2:0] MNEM_LEN [NUM_MNEM] = '{
        3'd3, 3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd2, 3'd3,
        3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3
    };

endpackage

// ===== hdl/assembly_token_classifier.sv =====
// Top level of the assembly token classifier: token state, result register.
// Depends on atc_pkg, atc_in_stage and atc_classify.
//
//  channel  direction  valid         stall         payload
//  input    in         i_in_valid    o_in_stall    i_in_data  (t_in_item)
//  output   out        o_out_valid   i_out_stall   o_out_data (t_out_item)
//
// One character per cycle while the output is not stalled. A character passes through the input
// register, then through the fold/compare/classify logic into the result register.
// Reset (i_rst_n low, synchronous) empties both registers and clears the token
// buffer, count, skip flag and line-open flag.
// A stall on the output holds the result register; the input register then fills
// and o_in_stall rises. Transactions that yield no result are consumed without
// touching the output.
module assembly_token_classifier #(
    parameter int unsigned TOKEN_CHARS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  atc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output atc_pkg::t_out_item o_out_data
);
    import atc_pkg::*;

    // count must reach TOKEN_CHARS + 1, the overlong mark
    localparam int unsigned CW = $clog2(TOKEN_CHARS + 2);
    localparam logic [CW-1:0] CNT_MAX  = CW'(TOKEN_CHARS);
    localparam logic [CW-1:0] CNT_LONG = CW'(TOKEN_CHARS + 1);
    localparam logic [CW-1:0] CNT_SAT  = CW'(7);

    // input register
    logic     w_in_valid;
    t_in_item w_item;
    logic     w_proc;

    // token state
    logic [31:0]   r_buf,  n_buf;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic          r_skip, n_skip;
    logic          r_open, n_open;

    // result register
    logic      r_out_valid;
    t_out_item r_out;
    logic      w_out_ready;

    // datapath
    logic [7:0]    w_ch;
    logic          w_delim;
    logic          w_take_ch;
    logic [31:0]   w_buf_add;
    logic [CW-1:0] w_cnt_add;
    logic [31:0]   w_cl_buf;
    logic [CW-1:0] w_cl_cnt;
    logic [2:0]    w_cl_len;
    logic [2:0]    w_kind;
    logic          w_do_close;
    logic          w_empty;
    logic          w_have;
    t_out_item     w_res;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_proc      = w_in_valid && w_out_ready;

    atc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_data    (i_in_data),
        .i_consume (w_proc),
        .o_valid   (w_in_valid),
        .o_data    (w_item)
    );

    // fold a-z to upper case, spot delimiters
    assign w_ch = (w_item.ch >= "a" && w_item.ch <= "z") ? (w_item.ch - 8'd32) : w_item.ch;
    assign w_delim = (w_ch == CH_SPACE) || (w_ch == CH_COMMA) || (w_ch == CH_SEMI);
    assign w_take_ch = w_item.ch_valid && !r_skip && !w_delim;

    // buffer and count after appending this character
    always_comb begin
        w_buf_add = r_buf;
        w_cnt_add = r_cnt;
        if (r_cnt < CNT_MAX) begin
            w_cnt_add = r_cnt + CW'(1);
            if (r_cnt < CW'(4)) begin
                w_buf_add = r_buf | ({24'h000000, w_ch} << {~r_cnt[1:0], 3'b000});
            end
        end else begin
            w_cnt_add = CNT_LONG;
        end
    end

    // token being closed: line end takes the just-appended character along
    assign w_cl_buf = w_take_ch ? w_buf_add : r_buf;
    assign w_cl_cnt = w_take_ch ? w_cnt_add : r_cnt;
    assign w_cl_len = (w_cl_cnt > CNT_SAT) ? 3'd7 : w_cl_cnt[2:0];

    atc_classify u_cls (
        .i_text (w_cl_buf),
        .i_len  (w_cl_len),
        .o_kind (w_kind)
    );

    // empty line: bare marker with line end before any character of the line
    assign w_empty    = w_item.line_end && !w_item.ch_valid && !r_open;
    assign w_do_close = !r_skip &&
                        ((w_item.ch_valid && w_delim) ||
                         (w_item.line_end && (w_item.ch_valid || r_open)));

    always_comb begin
        w_res  = '0;
        w_have = w_item.line_end;
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_skip = r_skip;
        n_open = r_open || w_item.ch_valid;

        if (w_do_close) begin
            n_buf = '0;
            n_cnt = '0;
            if (w_cl_cnt != '0) begin
                w_have = 1'b1;
                if (w_cl_cnt > CNT_MAX) begin
                    // overlong: drop the rest of the line
                    w_res.error_code = ERR_LONG;
                    n_skip           = 1'b1;
                end else begin
                    w_res.token_text   = w_cl_buf;
                    w_res.token_length = w_cl_len;
                    w_res.token_kind   = w_kind;
                    w_res.token_valid  = 1'b1;
                end
            end
        end else if (w_take_ch) begin
            n_buf = w_buf_add;
            n_cnt = w_cnt_add;
        end

        if (w_empty) begin
            w_res.error_code = ERR_EMPTY;
        end

        if (w_item.line_end) begin
            w_res.line_last = 1'b1;
            n_buf  = '0;
            n_cnt  = '0;
            n_skip = 1'b0;
            n_open = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_cnt  <= '0;
            r_skip <= 1'b0;
            r_open <= 1'b0;
        end else if (w_proc) begin
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_skip <= n_skip;
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_proc && w_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_have) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LONG)
        else $error("token count beyond overlong mark");

    a_err_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_code != ERR_NONE |-> !o_out_data.token_valid)
        else $error("error result carries a token");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_code == ERR_EMPTY |-> o_out_data.line_last)
        else $error("empty-line error without line_last");

    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_item.line_end |=> r_cnt == '0 && !r_skip && !r_open && r_buf == '0)
        else $error("line end left token state behind");

    a_line_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_item.line_end |=> o_out_valid && o_out_data.line_last)
        else $error("line end produced no closing result");
`endif

endmodule

// ===== hdl/atc_in_stage.sv =====
// Input register of the token classifier: holds one input transaction.
// Depends on atc_pkg for the transaction struct.
module atc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  atc_pkg::t_in_item i_data,
    input  logic              i_consume,
    output logic              o_valid,
    output atc_pkg::t_in_item o_data
);
    import atc_pkg::*;

    logic     r_valid;
    t_in_item r_data;
    logic     w_load;

    assign o_stall = r_valid && !i_consume;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/atc_classify.sv =====
// Keyword classifier: maps a token of up to four characters to its kind.
// Depends on atc_pkg for the mnemonic table and kind codes.
module atc_classify (
    input  logic [31:0] i_text,
    input  logic [2:0]  i_len,
    output logic [2:0]  o_kind
);
    import atc_pkg::*;

    logic       w_mnem;
    logic [7:0] w_c0;
    logic [7:0] w_c1;
    logic       w_vreg;

    assign w_c0 = i_text[31:24];
    assign w_c1 = i_text[23:16];

    always_comb begin
        w_mnem = 1'b0;
        for (int i = 0; i < NUM_MNEM; i++) begin
            if (i_len == MNEM_LEN[i] && i_text == MNEM_TEXT[i]) begin
                w_mnem = 1'b1;
            end
        end
    end

    // V1..V9 and VA..VF; V0 stays a value
    assign w_vreg = (i_len == 3'd2) && (w_c0 == "V") &&
                    (((w_c1 >= "1") && (w_c1 <= "9")) || ((w_c1 >= "A") && (w_c1 <= "F")));

    always_comb begin
        if (w_mnem) begin
            o_kind = KIND_INSTR;
        end else if (w_vreg) begin
            o_kind = KIND_REG8;
        end else if (i_len == 3'd2 && i_text == {"DT", 16'h0000}) begin
            o_kind = KIND_DELAY;
        end else if (i_len == 3'd2 && i_text == {"ST", 16'h0000}) begin
            o_kind = KIND_SOUND;
        end else if (i_len == 3'd1 && i_text == {"I", 24'h000000}) begin
            o_kind = KIND_ADDR;
        end else begin
            o_kind = KIND_VALUE;
        end
    end

endmodule
